[src/hmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_pkg
// Shared types and constants for the hoist motion profiler: operation codes,
// register map, duty levels and the request/result field layouts.
// ----------------------------------------------------------------------------
package hmp_pkg;

  // Geometry and duty constants
  localparam int unsigned POS_W       = 12;
  localparam int unsigned TOL_W       = 8;
  localparam int unsigned CREEP_W     = 8;
  localparam int unsigned SLOW_W      = 10;
  localparam int unsigned RAMP_W      = 6;
  localparam int unsigned RAMP_DEPTH  = 2 ** RAMP_W;
  localparam int unsigned DUTY_W      = 7;
  localparam int unsigned ACCEL_STEPS = 50;
  localparam int unsigned DUTY_MAX    = 100;
  localparam logic [DUTY_W-1:0] DUTY_SLOW  = 7'd30;
  localparam logic [DUTY_W-1:0] DUTY_CREEP = 7'd15;
  localparam logic [DUTY_W-1:0] DUTY_MAX_V = 7'd100;
  localparam logic [1:0] MISS_LIMIT = 2'd3;

  // Configuration port
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_FLOOR0    = 3'd0,
    REG_FLOOR1    = 3'd1,
    REG_FLOOR2    = 3'd2,
    REG_FLOOR3    = 3'd3,
    REG_TOLERANCE = 3'd4,
    REG_CREEP     = 3'd5,
    REG_SLOW      = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  localparam logic [POS_W-1:0]  FLOOR0_RST = 12'd0;
  localparam logic [POS_W-1:0]  FLOOR1_RST = 12'd300;
  localparam logic [POS_W-1:0]  FLOOR2_RST = 12'd600;
  localparam logic [POS_W-1:0]  FLOOR3_RST = 12'd900;
  localparam logic [TOL_W-1:0]  TOL_RST    = 8'd3;
  localparam logic [CREEP_W-1:0] CREEP_RST = 8'd15;
  localparam logic [SLOW_W-1:0] SLOW_RST   = 10'd60;

  typedef enum logic [1:0] {
    OP_GOTO    = 2'd0,
    OP_STOP    = 2'd1,
    OP_TICK    = 2'd2,
    OP_RELEVEL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_UNCHANGED = 3'd0,
    ST_MOVING    = 3'd1,
    ST_SLOWING   = 3'd2,
    ST_LEVELLING = 3'd3,
    ST_FAULT     = 3'd4
  } state_upd_t;

  // Request payload, last field in the lowest bits
  typedef struct packed {
    logic [DUTY_W-1:0] door_pct;
    logic              halt_request;
    logic [POS_W-1:0]  position_cm;
    logic [2:0]        target_floor;
  } req_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic              motion_active;
    logic              at_target;
    logic              level_fail;
    state_upd_t        state_update;
    logic              levelled;
    logic [DUTY_W-1:0] door_pct_out;
    logic [DUTY_W-1:0] duty_pct;
    dir_t              direction;
    logic              brake;
    logic              drive_valid;
    logic              goto_error;
  } res_t;

  localparam int unsigned IN_DW  = 24;
  localparam int unsigned OUT_DW = 32;

endpackage

[src/hoist_motion_profile.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hoist_motion_profile
// Hoist motion profiler: one request, one result, registered in and out.
// Each request passes through the input register, then the result register.
// Throughput: one request per cycle; the input stage and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst_n low, synchronous): floor, zone and tolerance registers load
// their defaults, motion state clears, both stages are emptied.
// ----------------------------------------------------------------------------
module hoist_motion_profile #(
  parameter int unsigned ACCEL_STEPS = hmp_pkg::ACCEL_STEPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // tdata: target_floor[2:0], position_cm[14:3], halt_request[15],
  //        door_pct[22:16], zero[23]
  input  logic [hmp_pkg::IN_DW-1:0]   in_tdata,
  // tuser: op[1:0]
  input  logic [1:0]                  in_tuser,
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // tdata: goto_error[0], drive_valid[1], brake[2], direction[4:3],
  //        duty_pct[11:5], door_pct_out[18:12], levelled[19],
  //        state_update[22:20], level_fail[23], at_target[24],
  //        motion_active[25], zero[31:26]
  output logic [hmp_pkg::OUT_DW-1:0]  out_tdata,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hmp_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [hmp_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [hmp_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import hmp_pkg::*;

  // Configuration registers
  logic [POS_W-1:0]   floor0_r, floor1_r, floor2_r, floor3_r;
  logic [TOL_W-1:0]   tol_r;
  logic [CREEP_W-1:0] creep_r;
  logic [SLOW_W-1:0]  slow_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // Motion state
  logic [POS_W-1:0]  target_r, target_nxt;
  logic [RAMP_W-1:0] ramp_r, ramp_nxt;
  logic [1:0]        misses_r, misses_nxt;
  logic              moving_r, moving_nxt;

  // Input stage
  logic       s1_valid_r;
  req_t       s1_req_r;
  op_t        s1_op_r;
  logic       s1_adv;

  // Result stage
  logic       out_valid_r;
  res_t       res_r, res_nxt;

  // Ramp duty table: step * DUTY_MAX / ACCEL_STEPS, fixed at elaboration
  logic [DUTY_W-1:0] ramp_duty [RAMP_DEPTH];
  for (genvar g = 0; g < RAMP_DEPTH; g++) begin : g_duty
    assign ramp_duty[g] = DUTY_W'((g * DUTY_MAX) / ACCEL_STEPS);
  end

  // Configuration access
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor0_r <= FLOOR0_RST;
      floor1_r <= FLOOR1_RST;
      floor2_r <= FLOOR2_RST;
      floor3_r <= FLOOR3_RST;
      tol_r    <= TOL_RST;
      creep_r  <= CREEP_RST;
      slow_r   <= SLOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FLOOR0:    floor0_r <= cfg_pwdata[POS_W-1:0];
        REG_FLOOR1:    floor1_r <= cfg_pwdata[POS_W-1:0];
        REG_FLOOR2:    floor2_r <= cfg_pwdata[POS_W-1:0];
        REG_FLOOR3:    floor3_r <= cfg_pwdata[POS_W-1:0];
        REG_TOLERANCE: tol_r    <= cfg_pwdata[TOL_W-1:0];
        REG_CREEP:     creep_r  <= cfg_pwdata[CREEP_W-1:0];
        REG_SLOW:      slow_r   <= cfg_pwdata[SLOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      REG_FLOOR0:    cfg_prdata = CFG_DW'(floor0_r);
      REG_FLOOR1:    cfg_prdata = CFG_DW'(floor1_r);
      REG_FLOOR2:    cfg_prdata = CFG_DW'(floor2_r);
      REG_FLOOR3:    cfg_prdata = CFG_DW'(floor3_r);
      REG_TOLERANCE: cfg_prdata = CFG_DW'(tol_r);
      REG_CREEP:     cfg_prdata = CFG_DW'(creep_r);
      REG_SLOW:      cfg_prdata = CFG_DW'(slow_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Stage handshake: advance when the result register can take a request
  assign s1_adv    = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r <= req_t'(in_tdata[$bits(req_t)-1:0]);
      s1_op_r  <= op_t'(in_tuser);
    end
  end

  // Profile logic
  logic [POS_W-1:0]   floor_sel;
  logic [POS_W-1:0]   gap_cm, gap_new;
  logic               within_tol;
  logic [RAMP_W-1:0]  ramp_inc;
  logic [1:0]         misses_inc;

  always_comb begin
    unique case (s1_req_r.target_floor[1:0])
      2'd0:    floor_sel = floor0_r;
      2'd1:    floor_sel = floor1_r;
      2'd2:    floor_sel = floor2_r;
      default: floor_sel = floor3_r;
    endcase
  end

  assign gap_cm = (s1_req_r.position_cm >= target_r) ?
                  (s1_req_r.position_cm - target_r) : (target_r - s1_req_r.position_cm);
  assign gap_new = (s1_req_r.position_cm >= target_nxt) ?
                   (s1_req_r.position_cm - target_nxt) :
                   (target_nxt - s1_req_r.position_cm);
  assign within_tol = (gap_cm <= POS_W'(tol_r));
  assign ramp_inc   = ramp_r + 1'b1;
  assign misses_inc = (misses_r < MISS_LIMIT) ? (misses_r + 1'b1) : misses_r;

  always_comb begin
    target_nxt = target_r;
    ramp_nxt   = ramp_r;
    misses_nxt = misses_r;
    moving_nxt = moving_r;
    res_nxt    = '0;

    unique case (s1_op_r)
      OP_GOTO: begin
        if (s1_req_r.target_floor[2]) begin
          res_nxt.goto_error = 1'b1;
        end else begin
          target_nxt = floor_sel;
          ramp_nxt   = '0;
          misses_nxt = '0;
          moving_nxt = 1'b1;
        end
      end
      OP_STOP: begin
        moving_nxt    = 1'b0;
        ramp_nxt      = '0;
        res_nxt.brake = 1'b1;
      end
      OP_TICK: begin
        if (moving_r) begin
          priority if (s1_req_r.halt_request) begin
            moving_nxt    = 1'b0;
            ramp_nxt      = '0;
            res_nxt.brake = 1'b1;
          end else if (within_tol) begin
            res_nxt.brake    = 1'b1;
            res_nxt.levelled = 1'b1;
            moving_nxt       = 1'b0;
          end else begin
            res_nxt.drive_valid  = 1'b1;
            res_nxt.direction    = (s1_req_r.position_cm < target_r) ? DIR_UP : DIR_DOWN;
            res_nxt.door_pct_out = s1_req_r.door_pct;
            priority if (gap_cm <= POS_W'(creep_r)) begin
              res_nxt.duty_pct     = DUTY_CREEP;
              res_nxt.state_update = ST_LEVELLING;
            end else if (gap_cm <= POS_W'(slow_r)) begin
              res_nxt.duty_pct     = DUTY_SLOW;
              res_nxt.state_update = ST_SLOWING;
            end else begin
              res_nxt.state_update = ST_MOVING;
              if (ramp_r < RAMP_W'(ACCEL_STEPS)) begin
                ramp_nxt         = ramp_inc;
                res_nxt.duty_pct = ramp_duty[ramp_inc];
              end else begin
                res_nxt.duty_pct = DUTY_MAX_V;
              end
            end
          end
        end
      end
      OP_RELEVEL: begin
        if (!within_tol) begin
          misses_nxt = misses_inc;
          if (misses_inc == MISS_LIMIT) begin
            moving_nxt           = 1'b0;
            ramp_nxt             = '0;
            res_nxt.brake        = 1'b1;
            res_nxt.level_fail   = 1'b1;
            res_nxt.state_update = ST_FAULT;
          end else begin
            moving_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res_nxt.at_target     = (gap_new <= POS_W'(tol_r));
    res_nxt.motion_active = moving_nxt;
  end

  // Commit state with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      ramp_r   <= '0;
      misses_r <= '0;
      moving_r <= 1'b0;
    end else if (s1_adv) begin
      target_r <= target_nxt;
      ramp_r   <= ramp_nxt;
      misses_r <= misses_nxt;
      moving_r <= moving_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(res_r);

endmodule

[bench/hoist_motion_profile_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hoist_motion_profile_tb
// Self-checking bench for the hoist motion profiler. A scoreboard model of
// the car state follows every accepted request and queues the result it
// should produce; each result taken from the block is compared field by
// field. Covers register access, directed corner cases, random journeys
// under several register settings, idle patterns on both sides and a long
// result-side stall that backs the block up.
// ----------------------------------------------------------------------------
module hoist_motion_profile_tb;
  import hmp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata    = '0;
  logic [1:0]          in_tuser    = '0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [CFG_DW-1:0]   cfg_pwdata  = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Scoreboard copy of the registers and the car state
  logic [POS_W-1:0]    floor_h [4];
  logic [TOL_W-1:0]    tol_cm;
  logic [CREEP_W-1:0]  creep_lim;
  logic [SLOW_W-1:0]   slow_cm;
  logic [POS_W-1:0]    target_h;
  logic [RAMP_W-1:0]   ramp_steps;
  logic [1:0]          miss_count;
  bit                  car_moving;

  res_t                pending_profiles [$];
  int unsigned         requests_sent = 0;
  int unsigned         mismatches    = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         quiet_cycles  = 0;
  int unsigned         hold_left     = 0;
  bit                  hold_request  = 1'b0;

  hoist_motion_profile u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Distance from a position to the current target height
  function automatic int unsigned gap_to_target(logic [POS_W-1:0] p);
    return (p >= target_h) ? int'(p) - int'(target_h) : int'(target_h) - int'(p);
  endfunction

  // Advance the car state by one request and return the result it gives
  function automatic res_t advance_profile(op_t op, req_t rq);
    res_t        r;
    int unsigned gap;
    int unsigned duty;
    r = '0;
    case (op)
      OP_GOTO: begin
        if (rq.target_floor > 3'd3) begin
          r.goto_error = 1'b1;
        end else begin
          target_h   = floor_h[rq.target_floor[1:0]];
          ramp_steps = '0;
          miss_count = '0;
          car_moving = 1'b1;
        end
      end
      OP_STOP: begin
        car_moving = 1'b0;
        ramp_steps = '0;
        r.brake    = 1'b1;
      end
      OP_TICK: begin
        if (car_moving && rq.halt_request) begin
          car_moving = 1'b0;
          ramp_steps = '0;
          r.brake    = 1'b1;
        end else if (car_moving) begin
          gap = gap_to_target(rq.position_cm);
          if (gap <= tol_cm) begin
            r.brake    = 1'b1;
            r.levelled = 1'b1;
            car_moving = 1'b0;
          end else begin
            r.drive_valid  = 1'b1;
            r.direction    = (rq.position_cm < target_h) ? DIR_UP : DIR_DOWN;
            r.door_pct_out = rq.door_pct;
            if (gap <= creep_lim) begin
              r.duty_pct     = DUTY_CREEP;
              r.state_update = ST_LEVELLING;
            end else if (gap <= slow_cm) begin
              r.duty_pct     = DUTY_SLOW;
              r.state_update = ST_SLOWING;
            end else begin
              r.state_update = ST_MOVING;
              if (ramp_steps < ACCEL_STEPS) begin
                ramp_steps = ramp_steps + 1'b1;
                duty       = (int'(ramp_steps) * DUTY_MAX) / ACCEL_STEPS;
                r.duty_pct = duty[DUTY_W-1:0];
              end else begin
                r.duty_pct = DUTY_MAX_V;
              end
            end
          end
        end
      end
      default: begin
        if (gap_to_target(rq.position_cm) > tol_cm) begin
          if (miss_count < MISS_LIMIT) miss_count = miss_count + 1'b1;
          if (miss_count == MISS_LIMIT) begin
            car_moving     = 1'b0;
            ramp_steps     = '0;
            r.brake        = 1'b1;
            r.level_fail   = 1'b1;
            r.state_update = ST_FAULT;
          end else begin
            car_moving = 1'b1;
          end
        end
      end
    endcase
    r.at_target     = (gap_to_target(rq.position_cm) <= tol_cm);
    r.motion_active = car_moving;
    return r;
  endfunction

  // Register value as the scoreboard holds it
  function automatic logic [31:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_FLOOR0, REG_FLOOR1, REG_FLOOR2, REG_FLOOR3: return 32'(floor_h[idx[1:0]]);
      REG_TOLERANCE: return 32'(tol_cm);
      REG_CREEP:     return 32'(creep_lim);
      REG_SLOW:      return 32'(slow_cm);
      default:       return '0;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // One configuration transfer: setup phase, then access until pready
  task automatic apb_transfer(bit write, reg_idx_t idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write every register, then read each one back
  task automatic load_setting(int unsigned f0, int unsigned f1, int unsigned f2,
                              int unsigned f3, int unsigned tol, int unsigned creep,
                              int unsigned slow);
    int unsigned vals [7];
    logic [31:0] rd;
    reg_idx_t    idx;
    int          i;
    vals = '{f0, f1, f2, f3, tol, creep, slow};
    for (i = 0; i < 7; i++) begin
      idx = reg_idx_t'(i);
      apb_transfer(1'b1, idx, vals[i], rd);
      case (idx)
        REG_FLOOR0, REG_FLOOR1, REG_FLOOR2, REG_FLOOR3:
          floor_h[idx[1:0]] = vals[i][POS_W-1:0];
        REG_TOLERANCE: tol_cm    = vals[i][TOL_W-1:0];
        REG_CREEP:     creep_lim = vals[i][CREEP_W-1:0];
        REG_SLOW:      slow_cm   = vals[i][SLOW_W-1:0];
        default: ;
      endcase
    end
    for (i = 0; i < 7; i++) begin
      idx = reg_idx_t'(i);
      apb_transfer(1'b0, idx, '0, rd);
      check_field($sformatf("register %s", idx.name()), reg_value(idx), rd);
    end
  endtask

  // Offer one request, hold it until taken, then queue its expected result
  task automatic send_item(op_t op, int unsigned floor_no, int unsigned pos,
                           bit halt, int unsigned door);
    req_t rq;
    rq.target_floor = floor_no[2:0];
    rq.position_cm  = pos[POS_W-1:0];
    rq.halt_request = halt;
    rq.door_pct     = door[DUTY_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, rq};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (op != OP_TICK || car_moving) requests_sent++;
    pending_profiles.push_back(advance_profile(op, rq));
  endtask

  // Drop valid, wait for every expected result, then let the pipe empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Position within a given spread of the target, clamped to the shaft
  function automatic int unsigned near_target(int unsigned spread);
    int p;
    p = int'(target_h) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(spread));
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return p;
  endfunction

  // One journey: go-to, ticks closing in on the target, then relevel checks
  task automatic drive_journey();
    int  pos;
    int  step;
    int  step_max;
    int  ticks_left;
    int  pick;
    bit  long_run;
    send_item(OP_GOTO, ($urandom_range(15) == 0) ? $urandom_range(7, 4) : $urandom_range(3),
              $urandom_range(4095), $urandom_range(1), $urandom_range(127));
    pos        = $urandom_range(4095);
    long_run   = ($urandom_range(7) == 0);
    ticks_left = long_run ? $urandom_range(80, 50) : $urandom_range(20, 1);
    step_max   = long_run ? 6 : 80;
    while (ticks_left != 0 && car_moving) begin
      pick = $urandom_range(long_run ? 199 : 19);
      case (pick)
        0: send_item(OP_TICK, $urandom_range(7), pos, 1'b1, $urandom_range(127));
        1: send_item(OP_RELEVEL, $urandom_range(7), near_target(tol_cm + 6),
                     $urandom_range(1), $urandom_range(127));
        2: send_item(OP_STOP, $urandom_range(7), $urandom_range(4095), $urandom_range(1),
                     $urandom_range(127));
        3: send_item(op_t'($urandom_range(3)), $urandom_range(7), $urandom_range(4095),
                     $urandom_range(1), $urandom_range(127));
        default: send_item(OP_TICK, $urandom_range(7), pos, 1'b0, $urandom_range(127));
      endcase
      // close in on the target; land near the tolerance edge when close
      step = $urandom_range(step_max);
      if (pos + step < int'(target_h)) pos = pos + step;
      else if (pos > int'(target_h) + step) pos = pos - step;
      else pos = near_target(tol_cm + 1);
      ticks_left--;
    end
    repeat ($urandom_range(4)) begin
      send_item(OP_RELEVEL, $urandom_range(7), near_target(tol_cm + 6), $urandom_range(1),
                $urandom_range(127));
    end
  endtask

  task automatic run_journeys(int unsigned goal);
    int unsigned stop_at;
    stop_at = requests_sent + goal;
    while (requests_sent < stop_at) drive_journey();
    drain_results();
  endtask

  // ---- Tests ----

  task automatic test_reset_registers();
    logic [31:0] rd;
    reg_idx_t    idx;
    int          i;
    for (i = 0; i < 7; i++) begin
      idx = reg_idx_t'(i);
      apb_transfer(1'b0, idx, '0, rd);
      check_field($sformatf("register %s", idx.name()), reg_value(idx), rd);
    end
  endtask

  // Corner cases under the reset floor heights, floor two at 600 cm
  task automatic test_directed_cases();
    send_item(OP_TICK,    0,    0, 1'b0,   0);  // tick while idle
    send_item(OP_GOTO,    7, 4095, 1'b1, 127);  // floor out of range
    send_item(OP_GOTO,    4,    0, 1'b0,   0);
    send_item(OP_GOTO,    2,    0, 1'b0,   0);
    send_item(OP_TICK,    0,    0, 1'b0,   0);  // far below, ramp starts
    send_item(OP_TICK,    0, 4095, 1'b0, 127);  // far above, door above 100
    send_item(OP_TICK,    0,  661, 1'b0,  50);  // just outside the slow zone
    send_item(OP_TICK,    0,  660, 1'b0, 100);  // slow zone edge
    send_item(OP_TICK,    0,  560, 1'b0, 101);
    send_item(OP_TICK,    0,  615, 1'b0,   1);  // creep zone edge
    send_item(OP_TICK,    0,  596, 1'b0,  64);  // creep upwards
    send_item(OP_TICK,    0,  100, 1'b1,  33);  // halt
    send_item(OP_TICK,    0,  100, 1'b0,  33);  // idle after halt
    send_item(OP_RELEVEL, 0,  603, 1'b0,   0);  // within tolerance
    send_item(OP_RELEVEL, 0,  604, 1'b0,   0);  // first miss re-enables
    send_item(OP_TICK,    0,  597, 1'b0,  20);  // levelled at the edge
    send_item(OP_RELEVEL, 0,    0, 1'b0,   0);  // second miss
    send_item(OP_RELEVEL, 0, 4095, 1'b1,   0);  // third miss faults
    send_item(OP_RELEVEL, 0, 4095, 1'b0,   0);  // fault repeats
    send_item(OP_GOTO,    0, 4095, 1'b0,   0);
    send_item(OP_TICK,    5, 4095, 1'b0, 127);
    send_item(OP_STOP,    6, 4095, 1'b1, 127);
    send_item(OP_GOTO,    3,  900, 1'b0,   0);
    send_item(OP_TICK,    3,  900, 1'b0,   0);  // levelled on the spot
    send_item(OP_GOTO,    1, 2048, 1'b0,   0);
    drain_results();
  endtask

  task automatic test_default_journeys(int unsigned goal);
    load_setting(FLOOR0_RST, FLOOR1_RST, FLOOR2_RST, FLOOR3_RST, TOL_RST, CREEP_RST,
                 SLOW_RST);
    run_journeys(goal);
  endtask

  task automatic test_low_extremes(int unsigned goal);
    load_setting(0, 4095, 1, 2048, 0, 0, 0);
    run_journeys(goal);
  endtask

  task automatic test_high_extremes(int unsigned goal);
    load_setting(4095, 0, 4094, 2047, 255, 255, 1023);
    run_journeys(goal);
  endtask

  task automatic test_random_settings(int unsigned goal);
    load_setting($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095), $urandom_range(12), $urandom_range(60),
                 $urandom_range(300));
    run_journeys(goal);
  endtask

  // Hold the result side off while requests keep coming
  task automatic test_backpressure(int unsigned goal);
    hold_request = 1'b1;
    run_journeys(goal);
  endtask

  // ---- Result side ----

  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[25:0]);
      if (pending_profiles.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_profiles.pop_front();
        check_field("goto_error",    32'(want.goto_error),    32'(got.goto_error));
        check_field("drive_valid",   32'(want.drive_valid),   32'(got.drive_valid));
        check_field("brake",         32'(want.brake),         32'(got.brake));
        check_field("direction",     32'(want.direction),     32'(got.direction));
        check_field("duty_pct",      32'(want.duty_pct),      32'(got.duty_pct));
        check_field("door_pct_out",  32'(want.door_pct_out),  32'(got.door_pct_out));
        check_field("levelled",      32'(want.levelled),      32'(got.levelled));
        check_field("state_update",  32'(want.state_update),  32'(got.state_update));
        check_field("level_fail",    32'(want.level_fail),    32'(got.level_fail));
        check_field("at_target",     32'(want.at_target),     32'(got.at_target));
        check_field("motion_active", 32'(want.motion_active), 32'(got.motion_active));
        check_field("tdata padding", '0,                      32'(out_tdata[31:26]));
      end
    end
  end

  // ---- Watchdog ----

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("hoist_motion_profile regression: fail");
    $finish;
  end

  // ---- Sequence ----

  initial begin
    floor_h    = '{FLOOR0_RST, FLOOR1_RST, FLOOR2_RST, FLOOR3_RST};
    tol_cm     = TOL_RST;
    creep_lim  = CREEP_RST;
    slow_cm    = SLOW_RST;
    target_h   = '0;
    ramp_steps = '0;
    miss_count = '0;
    car_moving = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 87;
    test_reset_registers();
    test_directed_cases();
    test_default_journeys(150);
    test_low_extremes(100);

    send_idle_pct = 87;
    recv_idle_pct = 12;
    test_high_extremes(100);
    test_random_settings(75);
    test_random_settings(75);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_settings(150);
    test_backpressure(50);

    if (mismatches == 0) begin
      $display("hoist_motion_profile regression: pass");
    end else begin
      $display("hoist_motion_profile regression: fail");
    end
    $finish;
  end

endmodule
